/* rtl/core/crcf_pkg.sv */
// Shared constants, types and the CRC byte update for the chunk framer.
package crcf_pkg;

  localparam int unsigned CRCF_QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  // Position of a byte within a framed packet.
  typedef enum logic [7:0] {
    STEP_OPEN   = 8'b0000_0001,
    STEP_TYPE   = 8'b0000_0010,
    STEP_LEN_HI = 8'b0000_0100,
    STEP_LEN_LO = 8'b0000_1000,
    STEP_DATA   = 8'b0001_0000,
    STEP_CRC_HI = 8'b0010_0000,
    STEP_CRC_LO = 8'b0100_0000,
    STEP_CLOSE  = 8'b1000_0000
  } crcf_step_t;

  // One classified input word, as handed from the front end to the back end.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  ftype;
    logic [15:0] len;
    logic [15:0] crc;
  } crcf_item_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crcf_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/crcf_ifs.sv */
// Valid/ready channel interfaces for the framer's input and output words.
interface crcf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_type;
  logic [15:0] chunk_length;

  modport source (output valid, payload_byte, frame_type, chunk_length, input ready);
  modport sink (input valid, payload_byte, frame_type, chunk_length, output ready);
endinterface

interface crcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink (input valid, out_byte, run_last, frame_end, output ready);
endinterface

/* rtl/core/crcf_front.sv */
// Front end: accepts payload words, tracks chunk state and the running CRC.
module crcf_front import crcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  crcf_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       q_push,
  output crcf_item_t q_item
);

  logic        in_chunk_r;
  logic [15:0] bytes_left_r;
  logic [15:0] crc_r;

  logic [15:0] len_eff;
  logic [15:0] left_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_nxt;
  logic        is_last;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    // A zero length is taken as a one-byte chunk.
    len_eff = (in_ch.chunk_length == 16'd0) ? 16'd1 : in_ch.chunk_length;
    if (!in_chunk_r) begin
      left_nxt = len_eff - 16'd1;
      crc_base = CRC_INIT;
    end else begin
      left_nxt = (bytes_left_r != 16'd0) ? (bytes_left_r - 16'd1) : 16'd0;
      crc_base = crc_r;
    end
    crc_nxt = crcf_crc_byte(crc_base, in_ch.payload_byte);
    is_last = (left_nxt == 16'd0);
  end

  always_comb begin
    q_item.first = !in_chunk_r;
    q_item.last  = is_last;
    q_item.data  = in_ch.payload_byte;
    q_item.ftype = in_ch.frame_type;
    q_item.len   = len_eff;
    q_item.crc   = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_chunk_r   <= 1'b0;
      bytes_left_r <= 16'd0;
      crc_r        <= CRC_INIT;
    end else if (q_push) begin
      in_chunk_r   <= !is_last;
      bytes_left_r <= left_nxt;
      crc_r        <= is_last ? CRC_INIT : crc_nxt;
    end
  end

  a_close_ends_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_item.last) |=> (!in_chunk_r && crc_r == CRC_INIT))
    else $error("chunk state not cleared after closing word");

endmodule

/* rtl/core/crcf_queue.sv */
// Small register queue between the front end and the back end.
module crcf_queue import crcf_pkg::*; #(
  parameter int unsigned DEPTH = CRCF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  crcf_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output crcf_item_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crcf_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_r + PTR_W'(1));
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_r + PTR_W'(1));
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

/* rtl/core/crcf_back.sv */
// Back end: expands each queued word into framed output bytes.
module crcf_back import crcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  crcf_item_t q_head,
  output logic       q_pop,
  crcf_out_if.source out_ch
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       frame_end_r;
  logic       started_r;
  crcf_step_t step_r;
  crcf_step_t step_nxt;

  crcf_step_t cur_step;
  crcf_step_t end_step;
  logic       at_end;
  logic       load;
  logic [7:0] byte_sel;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.frame_end = frame_end_r;

  assign load  = !q_empty && (!out_valid_r || out_ch.ready);
  assign q_pop = load && at_end;

  always_comb begin
    if (started_r) begin
      cur_step = step_r;
    end else begin
      cur_step = q_head.first ? STEP_OPEN : STEP_DATA;
    end
    end_step = q_head.last ? STEP_CLOSE : STEP_DATA;
    at_end   = (cur_step == end_step);
    case (cur_step)
      STEP_OPEN: begin
        byte_sel = OPEN_BRACE;
        step_nxt = STEP_TYPE;
      end
      STEP_TYPE: begin
        byte_sel = q_head.ftype;
        step_nxt = STEP_LEN_HI;
      end
      STEP_LEN_HI: begin
        byte_sel = q_head.len[15:8];
        step_nxt = STEP_LEN_LO;
      end
      STEP_LEN_LO: begin
        byte_sel = q_head.len[7:0];
        step_nxt = STEP_DATA;
      end
      STEP_DATA: begin
        byte_sel = q_head.data;
        step_nxt = STEP_CRC_HI;
      end
      STEP_CRC_HI: begin
        byte_sel = q_head.crc[15:8];
        step_nxt = STEP_CRC_LO;
      end
      STEP_CRC_LO: begin
        byte_sel = q_head.crc[7:0];
        step_nxt = STEP_CLOSE;
      end
      STEP_CLOSE: begin
        byte_sel = CLOSE_BRACE;
        step_nxt = STEP_OPEN;
      end
      default: begin
        byte_sel = q_head.data;
        step_nxt = STEP_OPEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      step_r      <= STEP_OPEN;
    end else if (load) begin
      out_valid_r <= 1'b1;
      started_r   <= !at_end;
      step_r      <= step_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= byte_sel;
      run_last_r  <= at_end;
      frame_end_r <= (cur_step == STEP_CLOSE);
    end
  end

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> run_last_r)
    else $error("closing brace not marked as last byte of its word");

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !q_empty)
    else $error("word in progress left the queue early");

endmodule

/* rtl/core/crc16_chunk_framer_core.sv */
// Top level of the CRC-16 chunk framer.
//
// The block turns a stream of payload words into framed chunks. The input
// channel (in_ch) carries one payload byte per word, plus the chunk type and
// length, which are read only on the first word of a chunk. That first word
// produces '{', the type, the length high byte then low byte, and the payload
// byte. Later words pass their byte through. The word that completes the
// declared length is followed by the CRC-16/CCITT-FALSE of the chunk payload,
// high byte first, and a closing '}' flagged by frame_end. run_last marks the
// final output byte caused by each input word.
// A front end classifies each word and updates the CRC in the cycle it is
// accepted; a queue of QUEUE_DEPTH words feeds a back end that emits one
// output byte per cycle while the receiver is ready, from a registered output
// stage. The first output byte of a word passes through the queue and then
// the output register, so it is presented once the word has reached the
// queue head and been loaded. A mid-chunk word yields one output byte, the
// opening word five, the closing word four and a one-byte chunk eight; input
// ready drops only when the queue is full.
// A stalled receiver holds the output word steady and backs up into the queue.
// Synchronous reset empties the queue and returns to awaiting a first byte.
module crc16_chunk_framer_core import crcf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = CRCF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  crcf_in_if.sink    in_ch,
  crcf_out_if.source out_ch
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  crcf_item_t q_push_item;
  crcf_item_t q_head;

  // Classify words and carry the chunk state and running CRC.
  crcf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  // Decouple the accept side from the byte-expansion side.
  crcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Emit header, payload, CRC and trailer bytes for the word at the queue head.
  crcf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the CRC-16 chunk framer core.
`timescale 1ns / 100ps

module testbench;
  import crcf_pkg::*;

  // Cycles without any accepted word on either channel before the run is
  // declared hung. The longest quiet stretch in a correct run is the deliberate
  // receiver hold plus one idle draw, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver hold, in cycles.
  localparam int HOLD_CYCLES = 80;
  // The hold starts after this many output words have been taken.
  localparam int HOLD_AFTER = 10;
  // Random chunks are started until this many words, directed ones included, are sent.
  localparam int RANDOM_WORDS = 110;
  // Mismatch lines printed before further mismatches are only counted.
  localparam int MAX_PRINTED = 40;

  // Holds the framer's expected output bytes and its own copy of the chunk
  // state. Every accepted input word is expanded here into the bytes that it
  // must produce, and every accepted output word is checked against the oldest
  // of them.
  class framer_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fend;
    } framed_byte_t;

    framed_byte_t due_bytes[$];
    bit           open;
    bit [15:0]    remaining;
    bit [15:0]    crc;
    int           errors;

    function new();
      open      = 1'b0;
      remaining = 16'd0;
      crc       = CRC_INIT;
      errors    = 0;
    endfunction

    task report(string what);
      if (errors < MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
      errors++;
    endtask

    // CRC-16/CCITT-FALSE, one bit per iteration: the feedback bit is the top
    // CRC bit xored with the next message bit, MSB first.
    function bit [15:0] crc_fold(bit [15:0] c, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void push_byte(bit [7:0] data, bit fend);
      framed_byte_t fb;
      fb.data = data;
      fb.last = 1'b0;
      fb.fend = fend;
      due_bytes.push_back(fb);
    endfunction

    function void note_word(bit [7:0] data, bit [7:0] kind, bit [15:0] len);
      bit [15:0] n;
      if (!open) begin
        // A declared length of zero is framed as a one-byte chunk.
        n = (len == 16'd0) ? 16'd1 : len;
        push_byte(OPEN_BRACE, 1'b0);
        push_byte(kind, 1'b0);
        push_byte(n[15:8], 1'b0);
        push_byte(n[7:0], 1'b0);
        remaining = n - 16'd1;
        crc       = CRC_INIT;
        open      = 1'b1;
      end else if (remaining != 16'd0) begin
        remaining--;
      end
      push_byte(data, 1'b0);
      crc = crc_fold(crc, data);
      if (remaining == 16'd0) begin
        push_byte(crc[15:8], 1'b0);
        push_byte(crc[7:0], 1'b0);
        push_byte(CLOSE_BRACE, 1'b1);
        open = 1'b0;
        crc  = CRC_INIT;
      end
      due_bytes[due_bytes.size() - 1].last = 1'b1;
    endfunction

    task check_byte(logic [7:0] data, logic last, logic fend);
      framed_byte_t want;
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected output byte %02h", data));
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        report($sformatf("out_byte %02h, expected %02h", data, want.data));
      end
      if (last !== want.last) begin
        report($sformatf("run_last %b, expected %b on byte %02h", last, want.last, want.data));
      end
      if (fend !== want.fend) begin
        report($sformatf("frame_end %b, expected %b on byte %02h", fend, want.fend, want.data));
      end
    endtask

    function int pending();
      return due_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  crcf_in_if  in_ch();
  crcf_out_if out_ch();

  crc16_chunk_framer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  framer_scoreboard board = new();

  // When set, both sides stop idling, so that back-to-back traffic is seen
  // as well as traffic with gaps on every phase of a frame.
  bit calm;
  int words_sent;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Offers one input word after a random gap and returns at the edge where
  // it is taken. The word is noted in the scoreboard at that edge.
  task automatic send_word(input logic [7:0] data, input logic [7:0] kind,
                           input logic [15:0] len);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= data;
    in_ch.frame_type   <= kind;
    in_ch.chunk_length <= len;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(data, kind, len);
    words_sent++;
  endtask

  // Sends a whole chunk of random payload. Words after the first carry random
  // type and length fields, which the block must ignore.
  task automatic send_chunk(input logic [7:0] kind, input logic [15:0] len);
    int n;
    n = (len == 16'd0) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        send_word(8'($urandom), kind, len);
      end else begin
        send_word(8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // Stimulus: reset, a directed set of chunks, random chunks, one opening word
  // of the largest length, then a drain and the verdict.
  initial begin
    int sel;
    logic [15:0] len;
    calm               = 1'b0;
    words_sent         = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= 8'h00;
    in_ch.frame_type   <= 8'h00;
    in_ch.chunk_length <= 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // One-byte chunk with all-zero byte and type: the largest burst of output words.
    send_word(8'h00, 8'h00, 16'd1);
    // Zero length is framed as length one; all-ones byte and type.
    send_word(8'hFF, 8'hFF, 16'd0);
    // Three-byte chunk. The later words drive all-ones and all-zero type and length,
    // which must not leak into the frame.
    send_word(8'hFF, 8'h5A, 16'd3);
    send_word(8'h00, 8'hFF, 16'hFFFF);
    send_word(8'hA5, 8'h00, 16'd0);
    // Brace values as type and as payload must pass through untouched.
    send_word(8'h7D, OPEN_BRACE, 16'd2);
    send_word(8'h7B, CLOSE_BRACE, 16'd1);
    // Top bit of the type, and a length whose high byte is nonzero only
    // through the later, ignored words.
    send_word(8'h01, 8'h80, 16'd1);
    send_word(8'h80, 8'h01, 16'd2);
    send_word(8'h7F, 8'hFF, 16'h8000);

    // Random chunks: mostly short ones, some longer, a few of zero length.
    // About one chunk in four runs without idling on either side.
    while (words_sent < RANDOM_WORDS) begin
      sel  = $urandom_range(0, 19);
      if (sel == 0) begin
        len = 16'd0;
      end else if (sel < 3) begin
        len = 16'($urandom_range(13, 30));
      end else begin
        len = 16'($urandom_range(1, 12));
      end
      calm = ($urandom_range(0, 3) == 0);
      send_chunk(8'($urandom), len);
    end

    // An opening word that declares the largest length, so both header length
    // bytes are all ones. The chunk is left open at the end of the run.
    calm = 1'b1;
    send_word(8'($urandom), 8'($urandom), 16'hFFFF);
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // Anything that still shows up now is an extra output word.
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: idles at random before each output word, and once holds ready
  // low for a long stretch so that the queue fills and input ready drops.
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap();
      repeat (gap) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_byte(out_ch.out_byte, out_ch.run_last, out_ch.frame_end);
      taken++;
      if (taken == HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule

/* sim.f */
rtl/core/crcf_pkg.sv
rtl/core/crcf_ifs.sv
rtl/core/crcf_front.sv
rtl/core/crcf_queue.sv
rtl/core/crcf_back.sv
rtl/core/crc16_chunk_framer_core.sv
tb/testbench.sv
